// ===== sv/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg: shared definitions for the local peak clipper
// Register indexes, fixed field widths and the result record.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Configuration register indexes and port widths.
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

  // Reset geometry and the fixed row limit.
  localparam int ResetWidth = 1024;
  localparam int RowLimit = 1024;
  localparam int RowW = 10;

  // Field widths of the streams.
  localparam int InPixW = 16;
  localparam int OutColW = 10;
  localparam int OutValW = 16;

  // Result queue: up to three results per pixel.
  localparam int MaxRes = 3;
  localparam int ResDepth = 4;
  localparam int ResPtrW = 2;
  localparam int ResCntW = 3;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic [OutValW-1:0] value;
    logic               done;
  } res_t;

endpackage

// ===== sv/lpc_ram.sv =====
// ----------------------------------------------------------------------------
// lpc_ram: generic single-port-write RAM
// One write port and one read port; read data is registered, read-first.
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/local_peak_clip_4_neighbor.sv =====
// ----------------------------------------------------------------------------
// local_peak_clip_4_neighbor: four-neighbour local maximum clipping
// A raster pixel stream is clipped in place; each finished pixel is reported
// with its row and column, and the last one of the frame flags frame end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  cfg     | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_stall_o| pixel_value_i
//  out     | out       | out_valid_o/stall_i  | out_row_o, out_col_o,
//          |           |                      | out_value_o, frame_done_o
//
// One pixel is taken per cycle while the result queue has room for three
// results; on the last row of a frame taller than one row, each pixel after
// the first column yields two results and the last column three, so there
// the single output port holds back the pixels with the queue's room.
// The first result of a pixel enters the result queue in the cycle after its transaction.
// Reset clears the position and queue and sets the reset geometry; the line
// buffer needs no clearing pass, since no result depends on an entry the current frame has not written.
// A stalled output only stops the input once the queue holds more than one result.
// ----------------------------------------------------------------------------
module local_peak_clip_4_neighbor #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lpc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lpc_pkg::InPixW-1:0]      pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lpc_pkg::RowW-1:0]        out_row_o,
  output logic [lpc_pkg::OutColW-1:0]     out_col_o,
  output logic [lpc_pkg::OutValW-1:0]     out_value_o,
  output logic                            frame_done_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int PixW = PIXEL_BITS;
  localparam int EntW = 2 * PixW;
  localparam int RowW = lpc_pkg::RowW;
  localparam int ResetLastCol =
      (lpc_pkg::ResetWidth > MAX_WIDTH ? MAX_WIDTH : lpc_pkg::ResetWidth) - 1;

  // Largest in-bounds neighbour if the centre is a strict peak, else centre.
  function automatic logic [PixW-1:0] clip_peak(input logic [PixW-1:0] center,
                                                input logic [3:0][PixW-1:0] nb,
                                                input logic [3:0] ok);
    logic [PixW-1:0] best;
    logic            any;
    logic            keep;
    best = '0;
    any  = 1'b0;
    keep = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (ok[k]) begin
        if (nb[k] >= center) keep = 1'b1;
        if (!any || nb[k] > best) best = nb[k];
        any = 1'b1;
      end
    end
    return (keep || !any) ? center : best;
  endfunction

  function automatic logic [lpc_pkg::OutColW-1:0] col_out(input logic [ColW-1:0] c);
    logic [ColW+lpc_pkg::OutColW-1:0] ext;
    ext = {{lpc_pkg::OutColW{1'b0}}, c};
    return ext[lpc_pkg::OutColW-1:0];
  endfunction

  function automatic logic [lpc_pkg::OutValW-1:0] val_out(input logic [PixW-1:0] v);
    logic [PixW+lpc_pkg::OutValW-1:0] ext;
    ext = {{lpc_pkg::OutValW{1'b0}}, v};
    return ext[lpc_pkg::OutValW-1:0];
  endfunction

  // Geometry and position.
  logic [ColW-1:0] last_col_q, last_col_d;
  logic [RowW-1:0] last_row_q, last_row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // Line buffer window: e0 is the entry at the current column.
  logic [EntW-1:0] e0_q, e0_d;
  logic [EntW-1:0] ram_rdata, rd_eff;
  logic [EntW-1:0] wdata;
  logic [ColW-1:0] raddr;
  logic            wr_hit_q, wr_hit_d;
  logic [EntW-1:0] wr_data_q;

  // Values carried from the previous pixel of the row.
  logic [PixW-1:0] prev_a_q, prev_a_d;
  logic [PixW-1:0] prev_b_q, prev_b_d;
  logic [PixW-1:0] prev_v_q, prev_v_d;

  // Result queue.
  lpc_pkg::res_t                fifo_q [lpc_pkg::ResDepth];
  lpc_pkg::res_t                fifo_d [lpc_pkg::ResDepth];
  logic [lpc_pkg::ResPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lpc_pkg::ResPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lpc_pkg::ResCntW-1:0]  cnt_q, cnt_d;

  logic                         in_acc, out_acc, cfg_acc;
  logic [PixW+lpc_pkg::InPixW-1:0] pix_ext;
  logic [PixW-1:0]              v;
  logic                         r_gt0, r_gt1, c_gt0, c_gt1, c_last, r_last;
  logic [PixW-1:0]              a_val, b_val, c_val;
  logic                         a_v, b_v, c_v;
  lpc_pkg::res_t                a_res, b_res, c_res;
  logic [31:0]                  wtmp, htmp;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign in_stall_o  = cnt_q > lpc_pkg::ResCntW'(lpc_pkg::ResDepth - lpc_pkg::MaxRes);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;

  assign out_row_o    = fifo_q[rd_ptr_q].row;
  assign out_col_o    = fifo_q[rd_ptr_q].col;
  assign out_value_o  = fifo_q[rd_ptr_q].value;
  assign frame_done_o = fifo_q[rd_ptr_q].done;

  assign pix_ext = {{PixW{1'b0}}, pixel_value_i};
  assign v       = pix_ext[PixW-1:0];

  assign r_gt0  = row_q != '0;
  assign r_gt1  = row_q > RowW'(1);
  assign c_gt0  = col_q != '0;
  assign c_gt1  = col_q > ColW'(1);
  assign c_last = col_q == last_col_q;
  assign r_last = row_q == last_row_q;

  // The write of the previous cycle may hit the address just read.
  assign rd_eff = wr_hit_q ? wr_data_q : ram_rdata;

  // Neighbour order in each call: above, below, left, right.
  assign a_val = clip_peak(e0_q[PixW-1:0],
                           {e0_q[EntW-1:PixW], v, prev_a_q, rd_eff[PixW-1:0]},
                           {r_gt1, 1'b1, c_gt0, !c_last});
  assign b_val = clip_peak(prev_v_q, {prev_a_q, {PixW{1'b0}}, prev_b_q, v},
                           {r_gt0, 1'b0, c_gt1, 1'b1});
  assign c_val = clip_peak(v, {a_val, {PixW{1'b0}}, b_val, {PixW{1'b0}}},
                           {r_gt0, 1'b0, c_gt0, 1'b0});

  assign a_v = in_acc && r_gt0;
  assign b_v = in_acc && r_last && c_gt0;
  assign c_v = in_acc && r_last && c_last;

  always_comb begin
    a_res       = '0;
    a_res.row   = row_q - RowW'(1);
    a_res.col   = col_out(col_q);
    a_res.value = val_out(a_val);
    a_res.done  = 1'b0;
    b_res       = '0;
    b_res.row   = row_q;
    b_res.col   = col_out(col_q - ColW'(1));
    b_res.value = val_out(b_val);
    b_res.done  = 1'b0;
    c_res       = '0;
    c_res.row   = row_q;
    c_res.col   = col_out(col_q);
    c_res.value = val_out(c_val);
    c_res.done  = 1'b1;
  end

  // Configuration: clamp into the legal range and restart the frame.
  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    wtmp       = 32'(cfg_data_i) - 32'd1;
    htmp       = 32'(cfg_data_i) - 32'd1;
    if (cfg_acc) begin
      case (cfg_index_i)
        lpc_pkg::RegImageWidth: begin
          if (cfg_data_i == '0) begin
            last_col_d = '0;
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            last_col_d = ColW'(MAX_WIDTH - 1);
          end else begin
            last_col_d = wtmp[ColW-1:0];
          end
        end
        lpc_pkg::RegImageHeight: begin
          if (cfg_data_i == '0) begin
            last_row_d = '0;
          end else if (32'(cfg_data_i) > 32'(lpc_pkg::RowLimit)) begin
            last_row_d = RowW'(lpc_pkg::RowLimit - 1);
          end else begin
            last_row_d = htmp[RowW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Position, line buffer window and carried values.
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    e0_d     = e0_q;
    prev_a_d = prev_a_q;
    prev_b_d = prev_b_q;
    prev_v_d = prev_v_q;
    wdata    = {a_val, v};
    if (cfg_acc) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (c_last) begin
        col_d = '0;
        row_d = r_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
      // With a single column the next entry is the one written now.
      e0_d     = (last_col_q == '0) ? wdata : rd_eff;
      prev_v_d = v;
      if (a_v) prev_a_d = a_val;
      if (b_v) prev_b_d = b_val;
    end
    raddr    = (col_d == last_col_q) ? '0 : col_d + ColW'(1);
    wr_hit_d = in_acc && (col_q == raddr);
  end

  // Result queue: results of one pixel are pushed in decision order.
  always_comb begin
    logic [lpc_pkg::ResPtrW-1:0] wp;
    logic [lpc_pkg::ResCntW-1:0] pushed;
    wp     = wr_ptr_q;
    pushed = '0;
    for (int i = 0; i < lpc_pkg::ResDepth; i++) begin
      fifo_d[i] = fifo_q[i];
    end
    if (a_v) begin
      fifo_d[wp] = a_res;
      wp         = wp + lpc_pkg::ResPtrW'(1);
      pushed     = pushed + lpc_pkg::ResCntW'(1);
    end
    if (b_v) begin
      fifo_d[wp] = b_res;
      wp         = wp + lpc_pkg::ResPtrW'(1);
      pushed     = pushed + lpc_pkg::ResCntW'(1);
    end
    if (c_v) begin
      fifo_d[wp] = c_res;
      wp         = wp + lpc_pkg::ResPtrW'(1);
      pushed     = pushed + lpc_pkg::ResCntW'(1);
    end
    wr_ptr_d = wp;
    rd_ptr_d = out_acc ? rd_ptr_q + lpc_pkg::ResPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + pushed - lpc_pkg::ResCntW'(out_acc);
  end

  lpc_ram #(
    .Width (EntW),
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= ColW'(ResetLastCol);
      last_row_q <= RowW'(lpc_pkg::RowLimit - 1);
      col_q      <= '0;
      row_q      <= '0;
      wr_hit_q   <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      col_q      <= col_d;
      row_q      <= row_d;
      wr_hit_q   <= wr_hit_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q      <= e0_d;
    wr_data_q <= wdata;
    prev_a_q  <= prev_a_d;
    prev_b_q  <= prev_b_d;
    prev_v_q  <= prev_v_d;
    for (int i = 0; i < lpc_pkg::ResDepth; i++) begin
      fifo_q[i] <= fifo_d[i];
    end
  end

endmodule

// ===== test/local_peak_clip_4_neighbor_tb.sv =====
// ----------------------------------------------------------------------------
// local_peak_clip_4_neighbor_tb: self-checking bench for the peak clipper
// Streams raster images through the clipper under random input gaps and output
// stalls. A scoreboard predicts every finished pixel and checks each result.
// The run covers directed frames, the geometry extremes and random frames.
// ----------------------------------------------------------------------------

class clip_scoreboard;

  localparam int MaxDim = 1024;

  logic [15:0]   final_row [MaxDim];
  logic [15:0]   pending_row [MaxDim];
  logic [15:0]   arriving_row [MaxDim];
  int            row_pos;
  int            col_pos;
  logic [10:0]   width_reg;
  logic [10:0]   height_reg;
  lpc_pkg::res_t expected_q [$];
  int unsigned   pixels;
  int unsigned   checked;
  int unsigned   frames;
  int unsigned   settings;
  int unsigned   failures;

  function new();
    foreach (final_row[i]) begin
      final_row[i] = '0;
      pending_row[i] = '0;
      arriving_row[i] = '0;
    end
    row_pos = 0;
    col_pos = 0;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    pixels = 0;
    checked = 0;
    frames = 0;
    settings = 0;
    failures = 0;
  endfunction

  function int clamp_dim(logic [10:0] d);
    if (d == 11'd0) return 1;
    if (d > MaxDim) return MaxDim;
    return int'(d);
  endfunction

  // Any register write restarts the frame at the top-left pixel.
  function void write_reg(logic [lpc_pkg::CfgIdxW-1:0] idx, logic [10:0] data);
    case (idx)
      lpc_pkg::RegImageWidth:  width_reg = data;
      lpc_pkg::RegImageHeight: height_reg = data;
      default: ;
    endcase
    row_pos = 0;
    col_pos = 0;
    settings++;
  endfunction

  // Neighbour slots: 0 right, 1 left, 2 below, 3 above.
  function logic [15:0] clip(logic [15:0] center, logic [3:0][15:0] nbs,
                             logic [3:0] present);
    logic        any;
    logic        blocked;
    logic [15:0] best;
    any = 1'b0;
    blocked = 1'b0;
    best = '0;
    for (int k = 0; k < 4; k++) begin
      if (present[k]) begin
        if (nbs[k] >= center) blocked = 1'b1;
        if (!any || nbs[k] > best) best = nbs[k];
        any = 1'b1;
      end
    end
    return (any && !blocked) ? best : center;
  endfunction

  function void decide(int r, int c, logic [15:0] center, logic [3:0][15:0] nbs,
                       logic [3:0] present, logic last);
    final_row[c] = clip(center, nbs, present);
    expected_q.push_back('{row: 10'(r), col: 10'(c), value: final_row[c], done: last});
  endfunction

  function void note_pixel(logic [15:0] v);
    int               w;
    int               h;
    int               r;
    int               c;
    int               p;
    logic [3:0][15:0] nbs;
    logic [3:0]       present;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    pixels++;
    arriving_row[c] = v;

    // The pixel above is finished now that its lower neighbour has arrived.
    if (r > 0) begin
      present = {r > 1, 1'b1, c > 0, c + 1 < w};
      nbs[0] = (c + 1 < w) ? pending_row[c + 1] : '0;
      nbs[1] = (c > 0) ? final_row[c - 1] : '0;
      nbs[2] = v;
      nbs[3] = final_row[c];
      decide(r - 1, c, pending_row[c], nbs, present, 1'b0);
    end

    // On the last row a pixel is finished once its right neighbour is here, the last one at once.
    if (r == h - 1) begin
      if (c > 0) begin
        p = c - 1;
        present = {r > 0, 1'b0, p > 0, 1'b1};
        nbs[0] = v;
        nbs[1] = (p > 0) ? final_row[p - 1] : '0;
        nbs[2] = '0;
        nbs[3] = final_row[p];
        decide(r, p, arriving_row[p], nbs, present, 1'b0);
      end
      if (c == w - 1) begin
        present = {r > 0, 1'b0, c > 0, 1'b0};
        nbs[0] = '0;
        nbs[1] = (c > 0) ? final_row[c - 1] : '0;
        nbs[2] = '0;
        nbs[3] = final_row[c];
        decide(r, c, v, nbs, present, 1'b1);
      end
    end

    c++;
    if (c >= w) begin
      c = 0;
      pending_row = arriving_row;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function void check_result(logic [9:0] row, logic [9:0] col, logic [15:0] value,
                             logic done);
    lpc_pkg::res_t want;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: row %0d col %0d value %h done %0b",
                 row, col, value, done);
    end else begin
      want = expected_q.pop_front();
      checked++;
      if (want.done) frames++;
      if (row !== want.row || col !== want.col || value !== want.value ||
          done !== want.done) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected row %0d col %0d value %h done %0b",
                   want.row, want.col, want.value, want.done);
          $display("          got row %0d col %0d value %h done %0b",
                   row, col, value, done);
        end
      end
    end
  endfunction

endclass

module local_peak_clip_4_neighbor_tb;

  localparam int ResetCycles  = 12;
  localparam int RandomPixels = 80;
  localparam int ShortRun     = 20;
  localparam int SettleCycles = 4;
  localparam int IdleLimit    = 4000;

  typedef enum int {ValFull, ValNarrow, ValTop} value_style_e;
  typedef enum int {RecvOpen, RecvLight, RecvHeavy, RecvPeriodic} recv_mode_e;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lpc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [lpc_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [lpc_pkg::InPixW-1:0]   pixel_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [lpc_pkg::RowW-1:0]     out_row;
  logic [lpc_pkg::OutColW-1:0]  out_col;
  logic [lpc_pkg::OutValW-1:0]  out_value;
  logic                         frame_done;

  clip_scoreboard board;
  int                  burst_left = 0;
  int                  idle_count = 0;
  int                  stall_tick = 0;
  recv_mode_e          recv_mode = RecvOpen;

  local_peak_clip_4_neighbor dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_value_i(pixel_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_value_o  (out_value),
    .frame_done_o (frame_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver periodically switches to a stall pattern picked at random.
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 80 == 0) recv_mode = recv_mode_e'($urandom_range(0, 3));
    case (recv_mode)
      RecvOpen:     out_stall <= 1'b0;
      RecvLight:    out_stall <= ($urandom_range(0, 3) == 0);
      RecvHeavy:    out_stall <= ($urandom_range(0, 3) != 0);
      RecvPeriodic: out_stall <= (stall_tick % 5 < 2);
      default:      out_stall <= 1'b0;
    endcase
  end

  // Every transaction is seen here, at the edge where it happens.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_pixel(pixel_value);
      if (out_valid && !out_stall) board.check_result(out_row, out_col, out_value, frame_done);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("no transaction for %0d cycles, %0d results still awaited",
               idle_count, board.expected_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  function automatic logic [15:0] pick_value(value_style_e style);
    case (style)
      ValNarrow: return 16'($urandom_range(0, 3));
      ValTop:    return 16'hFFFF - 16'($urandom_range(0, 2));
      default:   return 16'($urandom);
    endcase
  endfunction

  // Both registers are written back to back, with valid held high between them.
  task automatic configure(input logic [10:0] w, input logic [10:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= lpc_pkg::RegImageWidth;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= lpc_pkg::RegImageHeight;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int count, input value_style_e style);
    for (int i = 0; i < count; i++) send_pixel(pick_value(style));
  endtask

  // Drops valid, then waits for every predicted result before any register write.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    logic [15:0]  grid [9];
    int           random_sent;
    int           nframes;
    int           count;
    logic [10:0]  w;
    logic [10:0]  h;
    value_style_e style;

    board = new();
    random_sent = 0;
    // A tie on the top row, a peak in the middle and a peak in a corner.
    grid = '{16'd4, 16'd4, 16'd1, 16'd2, 16'd9, 16'd3, 16'hFFFF, 16'd5, 16'd5};

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Part of a frame at the reset geometry, abandoned by the register write.
    send_run(12, ValFull);
    settle();

    // Single-pixel frames pass straight through.
    configure(11'd1, 11'd0);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    settle();

    configure(11'd3, 11'd3);
    foreach (grid[i]) send_pixel(grid[i]);
    settle();

    // A zero width behaves as one column.
    configure(11'd0, 11'd2);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    settle();

    // An unfinished frame after some results have come out.
    configure(11'd4, 11'd3);
    send_run(6, ValNarrow);
    settle();

    // Oversized width and height saturate; each frame is cut short.
    configure(11'd2047, 11'd1);
    send_run(ShortRun, ValFull);
    settle();
    configure(11'd1, 11'd2047);
    send_run(ShortRun, ValNarrow);
    settle();

    while (random_sent < RandomPixels) begin
      w = 11'($urandom_range(0, 8));
      h = 11'($urandom_range(0, 6));
      configure(w, h);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes && random_sent < RandomPixels; f++) begin
        style = value_style_e'($urandom_range(0, 2));
        count = board.clamp_dim(w) * board.clamp_dim(h);
        if (f == nframes - 1 && $urandom_range(0, 5) == 0) count = $urandom_range(1, count);
        send_run(count, style);
        random_sent += count;
      end
      settle();
    end

    repeat (SettleCycles) @(posedge clk);
    $display("%0d pixels in, %0d results checked, %0d frames finished, %0d register writes",
             board.pixels, board.checked, board.frames, board.settings);
    $display("%0d mismatched or unexpected results", board.failures);
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== local_peak_clip_4_neighbor.f =====
sv/lpc_pkg.sv
sv/lpc_ram.sv
sv/local_peak_clip_4_neighbor.sv
test/local_peak_clip_4_neighbor_tb.sv
